>>> rtl/vmn_pkg.sv
// Shared widths and defaults for the vector magnitude and normalize core.
package vmn_pkg;
  localparam int unsigned IN_W          = 32;
  localparam int unsigned MAG_W         = 33;
  localparam int unsigned ROOT_W        = 32;
  localparam int unsigned SUM_W         = 2 * ROOT_W;
  localparam int unsigned FRAC_BITS_DEF = 16;
endpackage

>>> rtl/vmn_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a sideband bus.
module vmn_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [vmn_pkg::SUM_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [vmn_pkg::ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]           side_o
);
  localparam int unsigned N     = vmn_pkg::ROOT_W;
  localparam int unsigned RAD_W = 2 * N;
  localparam int unsigned REM_W = N + 4;

  logic             vld_q  [N+1];
  logic [RAD_W-1:0] rad_q  [N+1];
  logic [REM_W-1:0] rem_q  [N+1];
  logic [N-1:0]     root_q [N+1];
  logic [SIDE_W-1:0] side_q [N+1];

  assign vld_q[0]  = valid_i;
  assign rad_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [REM_W-1:0] cand;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign cand  = {rem_q[s][REM_W-3:0], rad_q[s][RAD_W-1 -: 2]};
    assign trial = {{(REM_W-N-2){1'b0}}, root_q[s], 2'b01};
    assign ge    = cand >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? (cand - trial) : cand;
      root_q[s+1] <= {root_q[s][N-2:0], ge};
      rad_q[s+1]  <= {rad_q[s][RAD_W-3:0], 2'b00};
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = vld_q[N];
  assign root_o  = root_q[N];
  assign side_o  = side_q[N];
endmodule

>>> rtl/vmn_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
module vmn_div #(
  parameter int unsigned FRAC_BITS = vmn_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [vmn_pkg::ROOT_W-1:0]           mag_i,
  input  logic [2:0][vmn_pkg::ROOT_W-1:0]      abs_i,
  input  logic [2:0]                           neg_i,
  output logic                                 valid_o,
  output logic [vmn_pkg::ROOT_W-1:0]           mag_o,
  output logic [2:0][FRAC_BITS:0]              quo_o,
  output logic [2:0]                           neg_o
);
  localparam int unsigned W = vmn_pkg::ROOT_W;
  localparam int unsigned S = FRAC_BITS + 1;

  logic                       vld_q [S+1];
  logic [W-1:0]               mag_q [S+1];
  logic [2:0]                 neg_q [S+1];
  logic [2:0][W:0]            rem_q [S+1];
  logic [2:0][FRAC_BITS:0]    quo_q [S+1];

  assign vld_q[0] = valid_i;
  assign mag_q[0] = mag_i;
  assign neg_q[0] = neg_i;
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem_q[0][l] = {1'b0, abs_i[l]};
    assign quo_q[0][l] = '0;
  end

  for (genvar j = 0; j < S; j++) begin : g_stage
    logic [2:0][W:0] sh;
    logic [2:0]      ge;

    for (genvar l = 0; l < 3; l++) begin : g_lane
      if (j == 0) begin : g_first
        assign sh[l] = rem_q[j][l];
      end else begin : g_rest
        assign sh[l] = {rem_q[j][l][W-1:0], 1'b0};
      end
      assign ge[l] = sh[l] >= {1'b0, mag_q[j]};

      always_ff @(posedge clk_i) begin
        rem_q[j+1][l] <= ge[l] ? (sh[l] - {1'b0, mag_q[j]}) : sh[l];
        quo_q[j+1][l] <= {quo_q[j][l][FRAC_BITS-1:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      mag_q[j+1] <= mag_q[j];
      neg_q[j+1] <= neg_q[j];
    end
  end

  assign valid_o = vld_q[S];
  assign mag_o   = mag_q[S];
  assign neg_o   = neg_q[S];
  assign quo_o   = quo_q[S];
endmodule

>>> rtl/vec3_magnitude_normalize_core.sv
// Top level: magnitude and unit vector of a signed fixed-point 3-vector.
//
// Usage: drive vec_x_i, vec_y_i, vec_z_i and raise start for one cycle per
// item; an item is taken at each rising edge with start high and busy low.
// busy stays low, so one item may enter in every cycle.
// Each result appears on magnitude_o, unit_x_o, unit_y_o, unit_z_o and
// zero_vector_o for exactly one cycle, marked by done_o.
// Pipeline order: absolute values, squaring, the sum, the square root (one
// root bit per stage), the dividers (one quotient bit per stage) and the
// output register. Throughput is one item per cycle, set by the fully
// pipelined root and divider stages.
// A zero vector gives magnitude zero, zero units and zero_vector_o high.
// Reset clears every valid bit, so no result comes out for items in flight.
// The receiver cannot stall; results are presented once and not held.
module vec3_magnitude_normalize_core #(
  parameter int unsigned FRAC_BITS = vmn_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [vmn_pkg::IN_W-1:0]   vec_x_i,
  input  logic signed [vmn_pkg::IN_W-1:0]   vec_y_i,
  input  logic signed [vmn_pkg::IN_W-1:0]   vec_z_i,
  output logic                              done_o,
  output logic [vmn_pkg::MAG_W-1:0]         magnitude_o,
  output logic signed [FRAC_BITS+1:0]       unit_x_o,
  output logic signed [FRAC_BITS+1:0]       unit_y_o,
  output logic signed [FRAC_BITS+1:0]       unit_z_o,
  output logic                              zero_vector_o
);
  localparam int unsigned W      = vmn_pkg::IN_W;
  localparam int unsigned R      = vmn_pkg::ROOT_W;
  localparam int unsigned SQ     = vmn_pkg::SUM_W;
  localparam int unsigned SIDE_W = 3 * W + 3;

  logic [2:0][W-1:0]  raw;
  logic [2:0][W-1:0]  abs_d;
  logic [2:0]         neg_d;

  logic               v1_q, v2_q, v3_q;
  logic [2:0][W-1:0]  abs1_q, abs2_q, abs3_q;
  logic [2:0]         neg1_q, neg2_q, neg3_q;
  logic [2:0][SQ-1:0] sq2_q;
  logic [SQ-1:0]      sum3_q;

  logic               sq_vld;
  logic [R-1:0]       sq_root;
  logic [SIDE_W-1:0]  sq_side;

  logic               dv_vld;
  logic [R-1:0]       dv_mag;
  logic [2:0][FRAC_BITS:0] dv_quo;
  logic [2:0]         dv_neg;

  logic [2:0][FRAC_BITS+1:0] unit_d;
  logic               zero_d;

  assign busy = 1'b0;

  assign raw = {vec_z_i, vec_y_i, vec_x_i};
  for (genvar l = 0; l < 3; l++) begin : g_abs
    assign neg_d[l] = raw[l][W-1];
    assign abs_d[l] = neg_d[l] ? (~raw[l] + W'(1)) : raw[l];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    abs1_q <= abs_d;
    neg1_q <= neg_d;
    for (int l = 0; l < 3; l++) begin
      sq2_q[l] <= {{W{1'b0}}, abs1_q[l]} * {{W{1'b0}}, abs1_q[l]};
    end
    abs2_q <= abs1_q;
    neg2_q <= neg1_q;
    sum3_q <= sq2_q[0] + sq2_q[1] + sq2_q[2];
    abs3_q <= abs2_q;
    neg3_q <= neg2_q;
  end

  vmn_sqrt #(
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (sum3_q),
    .side_i  ({neg3_q, abs3_q}),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  vmn_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .mag_i   (sq_root),
    .abs_i   (sq_side[3*W-1:0]),
    .neg_i   (sq_side[SIDE_W-1 -: 3]),
    .valid_o (dv_vld),
    .mag_o   (dv_mag),
    .quo_o   (dv_quo),
    .neg_o   (dv_neg)
  );

  assign zero_d = (dv_mag == '0);
  for (genvar l = 0; l < 3; l++) begin : g_unit
    assign unit_d[l] = zero_d     ? '0 :
                       dv_neg[l]  ? (~{1'b0, dv_quo[l]} + (FRAC_BITS+2)'(1)) :
                                    {1'b0, dv_quo[l]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    magnitude_o   <= {1'b0, dv_mag};
    unit_x_o      <= unit_d[0];
    unit_y_o      <= unit_d[1];
    unit_z_o      <= unit_d[2];
    zero_vector_o <= zero_d;
  end
endmodule
